// ===== rtl/core/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 5;
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 64;
    localparam int DEV_W       = 8;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY_REC = 2'd1,
        ST_FULL      = 2'd2,
        ST_POP_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } ram_req_t;

endpackage

// ===== rtl/core/binary_min_heap_queue.sv =====
// Insert starts at the first free slot; per level it reads the parent and compares, moving
// a larger parent down. Pop loads the root and last entry; per level it reads both children,
// picks the smaller and compares. Other requests go straight to done; one request at a time.
// Per-level cost is set by the registered heap memory read and the single key comparator.
// Result is held until taken; next request is accepted the cycle after it leaves.
// Reset empties the queue (fill count zero) and sets capacity to 16; no memory sweep.
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [DEV_W-1:0] dev_id,
    input  logic [KEY_W-1:0] timing,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [DEV_W-1:0] out_dev_id,
    output logic [KEY_W-1:0] out_timing,
    output logic [CNT_W-1:0] queue_length,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             cfg_clear;
    ram_req_t         ram_req;
    entry_t           rdata_a;
    entry_t           rdata_b;

    assign cfg_ready = 1'b1;

    // Drop out-of-range capacity; a valid one empties the queue
    assign cfg_clear     = cfg_valid && cfg_ready && cfg_data <= CAP_W'(MAX_ENTRIES);
    assign capacity_next = cfg_clear ? cfg_data : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(MAX_ENTRIES);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    bmhq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .dev_id     (dev_id),
        .timing     (timing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_dev_id (out_dev_id),
        .out_timing (out_timing),
        .fill_count (queue_length),
        .capacity   (capacity_reg),
        .cfg_clear  (cfg_clear),
        .ram_req    (ram_req),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b)
    );

    bmhq_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

endmodule

// ===== rtl/core/bmhq_ram.sv =====
// Heap storage: one write port, two registered read ports.
module bmhq_ram
    import bmhq_pkg::*;
(
    input  logic     clk,
    input  ram_req_t ram_req,
    output entry_t   rdata_a,
    output entry_t   rdata_b
);

    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[ram_req.raddr_a];
        rdata_b <= mem[ram_req.raddr_b];
    end

endmodule

// ===== rtl/core/bmhq_ctrl.sv =====
// Request sequencer with one shared key comparator for sift up and sift down.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [DEV_W-1:0] dev_id,
    input  logic [KEY_W-1:0] timing,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [DEV_W-1:0] out_dev_id,
    output logic [KEY_W-1:0] out_timing,
    output logic [CNT_W-1:0] fill_count,
    input  logic [CAP_W-1:0] capacity,
    input  logic             cfg_clear,
    output ram_req_t         ram_req,
    input  entry_t           rdata_a,
    input  entry_t           rdata_b
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_SEL,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [IDX_W-1:0] cidx_reg,   cidx_next;
    entry_t           cur_reg,    cur_next;
    entry_t           child_reg,  child_next;
    logic [1:0]       status_reg, status_next;
    logic [DEV_W-1:0] odev_reg,   odev_next;
    logic [KEY_W-1:0] okey_reg,   okey_next;

    logic             in_fire;
    logic [KEY_W-1:0] cmp_lhs;
    logic [KEY_W-1:0] cmp_rhs;
    logic             cmp_lt;
    logic [IDX_W-1:0] parent_idx;
    logic [IDX_W+1:0] left_idx;
    logic [IDX_W+1:0] right_idx;
    logic [IDX_W+1:0] fill_ext;
    logic             left_out;
    logic             right_out;

    assign in_fire    = in_valid && in_ready;
    assign parent_idx = IDX_W'((idx_reg - IDX_W'(1)) >> 1);
    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = {1'b0, idx_reg, 1'b0} + (IDX_W+2)'(2);
    assign fill_ext   = (IDX_W+2)'(fill_reg);
    assign left_out   = left_idx >= fill_ext;
    assign right_out  = right_idx >= fill_ext;

    // Shared comparator: operands steered by the sequencer
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_lhs = cur_reg.key;
                cmp_rhs = rdata_a.key;
            end
            S_DN_SEL:
            begin
                cmp_lhs = rdata_a.key;
                cmp_rhs = rdata_b.key;
            end
            default:
            begin
                cmp_lhs = child_reg.key;
                cmp_rhs = cur_reg.key;
            end
        endcase
    end

    assign cmp_lt = cmp_lhs < cmp_rhs;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        cidx_next   = cidx_reg;
        cur_next    = cur_reg;
        child_next  = child_reg;
        status_next = status_reg;
        odev_next   = odev_reg;
        okey_next   = okey_reg;

        ram_req.we      = 1'b0;
        ram_req.waddr   = idx_reg;
        ram_req.wdata   = cur_reg;
        ram_req.raddr_a = '0;
        ram_req.raddr_b = '0;

        case (state_reg)
            S_IDLE:
            begin
                ram_req.raddr_b = IDX_W'(fill_reg - CNT_W'(1));
                if (in_fire)
                begin
                    status_next = ST_DONE;
                    odev_next   = '0;
                    okey_next   = '0;
                    state_next  = S_DONE;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (dev_id == '0 && timing == '0)
                            begin
                                status_next = ST_EMPTY_REC;
                            end
                            else if (fill_reg >= capacity ||
                                     fill_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cur_next.dev = dev_id;
                                cur_next.key = timing;
                                idx_next     = IDX_W'(fill_reg);
                                fill_next    = fill_reg + CNT_W'(1);
                                state_next   = S_UP_RD;
                            end
                        end
                        REQ_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP_LD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                ram_req.raddr_a = parent_idx;
                if (idx_reg == '0)
                begin
                    ram_req.we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_req.we = 1'b1;
                // parent strictly larger: move it down into the hole
                if (cmp_lt)
                begin
                    ram_req.wdata = rdata_a;
                    idx_next      = parent_idx;
                    state_next    = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_LD:
            begin
                odev_next  = rdata_a.dev;
                okey_next  = rdata_a.key;
                cur_next   = rdata_b;
                fill_next  = fill_reg - CNT_W'(1);
                idx_next   = '0;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                ram_req.raddr_a = IDX_W'(left_idx);
                ram_req.raddr_b = IDX_W'(right_idx);
                if (left_out)
                begin
                    ram_req.we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_SEL;
                end
            end
            S_DN_SEL:
            begin
                // ties go to the right child
                if (right_out || cmp_lt)
                begin
                    child_next = rdata_a;
                    cidx_next  = IDX_W'(left_idx);
                end
                else
                begin
                    child_next = rdata_b;
                    cidx_next  = IDX_W'(right_idx);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_req.we = 1'b1;
                if (cmp_lt)
                begin
                    ram_req.wdata = child_reg;
                    idx_next      = cidx_reg;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            idx_reg    <= '0;
            cidx_reg   <= '0;
            cur_reg    <= '0;
            child_reg  <= '0;
            status_reg <= ST_DONE;
            odev_reg   <= '0;
            okey_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            cidx_reg   <= cidx_next;
            cur_reg    <= cur_next;
            child_reg  <= child_next;
            status_reg <= status_next;
            odev_reg   <= odev_next;
            okey_reg   <= okey_next;
        end
    end

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = state_reg == S_DONE;
    assign status     = status_reg;
    assign out_dev_id = odev_reg;
    assign out_timing = okey_reg;
    assign fill_count = fill_reg;

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && req_type == REQ_POP && fill_reg == '0
        |=> state_reg == S_DONE && status_reg == ST_POP_EMPTY)
        else $error("pop on empty queue not reported");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_reg != ST_DONE |-> odev_reg == '0 && okey_reg == '0)
        else $error("refused request carries a record");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond storage depth");

    a_write_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> state_reg == S_UP_RD || state_reg == S_UP_CMP ||
                       state_reg == S_DN_RD || state_reg == S_DN_CMP)
        else $error("heap write outside a sift");

endmodule
